// File: sv/line_fold_at_last_blank_unit_macros.svh
// Assertion macros used by the line folder controller.
`ifndef LINE_FOLD_AT_LAST_BLANK_UNIT_MACROS_SVH
`define LINE_FOLD_AT_LAST_BLANK_UNIT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define LFOLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after the trigger.
`define LFOLD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lfold_pkg.sv
// Package: constants, state type and chain control struct of the line folder.
package lfold_pkg;

  localparam int unsigned LF_MAX_WIDTH = 40;
  localparam int unsigned LF_FOLD_W    = 6;
  localparam int unsigned LF_CHAR_W    = 8;

  localparam logic [LF_FOLD_W-1:0] LF_FOLD_RESET = 6'd40;
  localparam logic [LF_CHAR_W-1:0] LF_NEWLINE    = 8'h0A;
  localparam logic [LF_CHAR_W-1:0] LF_BLANK      = 8'h20;
  localparam logic [LF_CHAR_W-1:0] LF_FILL_CHAR  = 8'h00;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Control broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                 shift;
    logic                 wr;
    logic [LF_CHAR_W-1:0] wr_char;
  } chain_ctrl_t;

endpackage

// File: sv/lfold_cell.sv
// One character cell of the line buffer chain.
module lfold_cell
  import lfold_pkg::*;
(
  input  logic                 clk_i,
  input  chain_ctrl_t          ctrl_i,
  input  logic                 sel_i,
  input  logic [LF_CHAR_W-1:0] next_i,
  output logic [LF_CHAR_W-1:0] char_o
);

  logic [LF_CHAR_W-1:0] char_q;
  logic [LF_CHAR_W-1:0] char_d;

  // shift takes the right neighbor, write takes the broadcast character
  always_comb begin
    char_d = char_q;
    if (ctrl_i.shift) begin
      char_d = next_i;
    end else if (ctrl_i.wr && sel_i) begin
      char_d = ctrl_i.wr_char;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

// File: sv/lfold_ctrl.sv
// Controller: fill and blank tracking, fold decision, emit sequencer, output register.
`include "line_fold_at_last_blank_unit_macros.svh"

module lfold_ctrl
  import lfold_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = LF_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned IW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [LF_CHAR_W-1:0] in_char_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LF_CHAR_W-1:0] out_char_o,
  output logic                 out_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LF_FOLD_W-1:0] cfg_fold_width_i,
  input  logic [LF_CHAR_W-1:0] head_char_i,
  output chain_ctrl_t          chain_o,
  output logic [IW-1:0]        widx_o
);

  state_e state_q, state_d;

  logic [LF_FOLD_W-1:0] fold_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic                 bs_q, bs_d;
  logic [IW-1:0]        bp_q, bp_d;
  logic [CW-1:0]        rem_q, rem_d;

  logic                 out_valid_q, out_valid_d;
  logic [LF_CHAR_W-1:0] out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic                 in_acc, is_nl, is_blank, fire;
  logic                 slot_free, beat_ld, char_beat, nl_beat;
  logic [LF_FOLD_W-1:0] width_eff;
  logic [IW-1:0]        widx;
  logic [CW-1:0]        f1, rest;
  logic                 bs_new;
  logic [IW-1:0]        bp_new;

  assign cfg_ready_o = 1'b1;

  // fold width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= LF_FOLD_RESET;
    end else if (cfg_valid_i) begin
      fold_q <= cfg_fold_width_i;
    end
  end

  // fold decision for the incoming character
  always_comb begin
    width_eff = (fold_q > LF_FOLD_W'(MAX_WIDTH)) ? LF_FOLD_W'(MAX_WIDTH) : fold_q;
    widx      = (fill_q >= CW'(MAX_WIDTH)) ? IW'(MAX_WIDTH - 1) : fill_q[IW-1:0];
    is_nl     = (in_char_i == LF_NEWLINE);
    is_blank  = (in_char_i == LF_BLANK);
    f1        = CW'(widx) + CW'(1);
    bs_new    = bs_q | is_blank;
    bp_new    = is_blank ? widx : bp_q;
    rest      = f1 - CW'(bp_new) - CW'(1);
    fire      = is_nl || (LF_FOLD_W'(f1) >= width_eff);
  end

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && fire) state_d = ST_EMIT;
      ST_EMIT: if (nl_beat) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    beat_ld    = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EMIT: beat_ld    = slot_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign char_beat = beat_ld && (rem_q != '0);
  assign nl_beat   = beat_ld && (rem_q == '0);

  // line bookkeeping and emit count
  always_comb begin
    fill_d = fill_q;
    bs_d   = bs_q;
    bp_d   = bp_q;
    rem_d  = rem_q;
    if (in_acc) begin
      if (is_nl) begin
        rem_d  = fill_q;
        fill_d = '0;
        bs_d   = 1'b0;
      end else if (!fire) begin
        fill_d = f1;
        bs_d   = bs_new;
        bp_d   = bp_new;
      end else if (!bs_new) begin
        rem_d  = f1;
        fill_d = '0;
        bs_d   = 1'b0;
      end else begin
        // emit up to the blank; the newline beat's shift drops the blank
        rem_d  = CW'(bp_new);
        fill_d = rest;
        bs_d   = 1'b0;
        bp_d   = '0;
      end
    end else if (char_beat) begin
      rem_d = rem_q - CW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (char_beat) begin
      out_valid_d = 1'b1;
      out_char_d  = head_char_i;
      out_last_d  = 1'b0;
    end else if (nl_beat) begin
      out_valid_d = 1'b1;
      out_char_d  = LF_NEWLINE;
      out_last_d  = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bs_q        <= 1'b0;
      bp_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bs_q        <= bs_d;
      bp_q        <= bp_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // chain control: write in idle, shift on every emitted beat
  assign chain_o.shift   = beat_ld;
  assign chain_o.wr      = in_acc && !is_nl;
  assign chain_o.wr_char = in_char_i;
  assign widx_o          = widx;

  // checks
  `LFOLD_ASSERT(a_fill_below_max, fill_q <= CW'(MAX_WIDTH - 1), "fill count reached the depth")
  `LFOLD_ASSERT(a_blank_inside, !bs_q || (CW'(bp_q) < fill_q), "blank position past fill")
  `LFOLD_ASSERT_NEXT(a_nl_ends_run, nl_beat,
    (state_q == ST_IDLE) && out_valid_o && out_last_o && (out_char_o == LF_NEWLINE),
    "newline beat did not close the run")
  `LFOLD_ASSERT_NEXT(a_nl_clears, in_acc && is_nl, (fill_q == '0) && !bs_q,
    "newline did not clear the line")

endmodule

// File: sv/line_fold_at_last_blank_unit.sv
// Top level: line folder built from a chain of character cells and a controller.
//
// Word-wrap line folder. One character byte enters per input beat. The line is
// held in a row of MAX_WIDTH character cells; the controller writes a new
// character into the cell at the fill position and tracks the last blank. A
// newline, or reaching fold_width (capped at MAX_WIDTH), starts a run: the
// chain shifts toward its head once per output beat and the head cell feeds the
// output register, followed by a newline beat with out_last set. When the fold
// is at a blank the newline beat's shift also drops the blank, leaving the rest
// of the line at the front of the chain. A character that causes no output is
// simply accepted; one that emits k characters (k at most MAX_WIDTH) is accepted,
// then followed by k character beats and a newline beat, one output beat per
// cycle taken from the head of the chain while the output does not stall. The
// input stalls during a run; the fold width register is always ready. An
// unterminated final line stays buffered.
module line_fold_at_last_blank_unit
  import lfold_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = LF_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [LF_CHAR_W-1:0] in_char_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LF_CHAR_W-1:0] out_char_o,
  output logic                 out_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LF_FOLD_W-1:0] cfg_fold_width_i
);

  localparam int unsigned IW = $clog2(MAX_WIDTH);

  chain_ctrl_t          chain;
  logic [IW-1:0]        widx;
  logic [LF_CHAR_W-1:0] cell_char [MAX_WIDTH];

  lfold_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_last_o       (out_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_fold_width_i (cfg_fold_width_i),
    .head_char_i      (cell_char[0]),
    .chain_o          (chain),
    .widx_o           (widx)
  );

  // row of cells; each shifts toward the head, the tail takes filler
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [LF_CHAR_W-1:0] next_char;
    logic                 sel;

    if (i == MAX_WIDTH - 1) begin : g_tail
      assign next_char = LF_FILL_CHAR;
    end else begin : g_body
      assign next_char = cell_char[i+1];
    end

    assign sel = (widx == IW'(i));

    lfold_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (chain),
      .sel_i  (sel),
      .next_i (next_char),
      .char_o (cell_char[i])
    );
  end

endmodule
